// ===== src/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc_pkg
// shared widths, codes and result types of the display write coalescer
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int COORD_W  = 10;
  localparam int PIX_W    = 16;
  localparam int OFFS_W   = 16;
  localparam int RW_W     = 11;
  localparam int BR_W     = 7;
  localparam int CAP_W    = RW_W + BR_W;
  localparam int PITCH_W  = COORD_W + 1;
  localparam int BASE_W   = COORD_W + PITCH_W;
  localparam int IDX_W    = 2;
  localparam int CFG_W    = RW_W;

  localparam int PIX_BYTES = 2;
  localparam logic [PIX_W-1:0] PIX_MASK =
    (8 * PIX_BYTES >= PIX_W) ? {PIX_W{1'b1}} :
    PIX_W'((1 << (8 * PIX_BYTES)) - 1);

  localparam logic [RW_W-1:0] ROW_WIDTH_RST = RW_W'(320);
  localparam logic [BR_W-1:0] BUF_ROWS_RST  = BR_W'(16);

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // result kind codes
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_BUF_ROWS  = 2'd1;

  typedef struct packed {
    logic               kind;
    logic [OFFS_W-1:0]  offset;
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0]       n;
    result_t [2:0]    item;
  } res_list_t;

endpackage

// ===== src/display_write_coalescer_top.sv =====
// ----------------------------------------------------------------------------
// display_write_coalescer_top
// gathers pixel writes into a dirty window and emits stores and draw rectangles
// ----------------------------------------------------------------------------
// usage
//   in_*  : one command per transfer; in_tuser 0 = pixel write, 1 = flush.
//           a write gives one store result, preceded by one or two draw
//           rectangles when it has to close the current window first.
//   out_* : one result per transfer; out_tuser 0 = store, 1 = draw;
//           out_tlast marks the final result caused by one command.
//   cfg_* : row_width (index 0) and buffer row count (index 1); always ready,
//           written only while the block is idle, a rule for the user that the
//           block does not enforce. capacity is registered from both registers.
// latency : the first result of a command is shown the cycle after its
//           transfer; further results follow one a cycle while out_tready is high.
// throughput : one command a cycle while each gives a single result and out_tready
//           is high; a command giving more results holds the input until the
//           three-slot result register, draining one per ready cycle, holds its last.
// reset   : synchronous, active low; no window open, registers at 320 / 16,
//           no result pending.
// stall   : while out_tready is low, results hold and in_tready drops once
//           the last waiting result cannot leave.
// ----------------------------------------------------------------------------
module display_write_coalescer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,  // x, y, pixel_value, zero pad
  input  logic                          in_tuser,  // cmd
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [71:0]                   out_tdata, // buffer_offset, store_pixel,
                                                   // left, top, right, bottom
  output logic                          out_tuser, // kind
  output logic                          out_tlast, // last
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dwc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dwc_pkg::CFG_W-1:0]     cfg_data
);

  logic [dwc_pkg::CAP_W-1:0] cap;
  logic                      in_xfer;
  dwc_pkg::res_list_t        list;
  dwc_pkg::result_t          res;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;

  dwc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cap      (cap)
  );

  // input fields unpacked straight off the bus
  dwc_window u_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_xfer),
    .cmd    (in_tuser),
    .x      (in_tdata[9:0]),
    .y      (in_tdata[19:10]),
    .pix    (in_tdata[35:20]),
    .cap    (cap),
    .list   (list)
  );

  dwc_result_queue u_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .list       (list),
    .load_ready (in_tready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // result fields packed from the lowest bit up
  assign out_tdata = {res.bottom, res.right, res.top, res.left, res.pixel, res.offset};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== src/dwc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dwc_cfg_regs
// configuration registers and registered buffer capacity
// ----------------------------------------------------------------------------
module dwc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [dwc_pkg::IDX_W-1:0]      wr_index,
  input  logic [dwc_pkg::CFG_W-1:0]      wr_data,
  output logic [dwc_pkg::CAP_W-1:0]      cap
);

  logic [dwc_pkg::RW_W-1:0]  row_width_r;
  logic [dwc_pkg::BR_W-1:0]  buf_rows_r;
  logic [dwc_pkg::CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= dwc_pkg::ROW_WIDTH_RST;
      buf_rows_r  <= dwc_pkg::BUF_ROWS_RST;
      cap_r       <= dwc_pkg::CAP_W'(dwc_pkg::ROW_WIDTH_RST) *
                     dwc_pkg::CAP_W'(dwc_pkg::BUF_ROWS_RST);
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          dwc_pkg::REG_ROW_WIDTH: row_width_r <= wr_data[dwc_pkg::RW_W-1:0];
          dwc_pkg::REG_BUF_ROWS:  buf_rows_r  <= wr_data[dwc_pkg::BR_W-1:0];
          default: ;
        endcase
      end
      // capacity in pixels, registered from the current register values
      cap_r <= dwc_pkg::CAP_W'(row_width_r) * dwc_pkg::CAP_W'(buf_rows_r);
    end
  end

  assign cap = cap_r;

endmodule

// ===== src/dwc_window.sv =====
// ----------------------------------------------------------------------------
// dwc_window
// dirty window state and the result list caused by one input item
// ----------------------------------------------------------------------------
module dwc_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            cmd,
  input  logic [dwc_pkg::COORD_W-1:0]     x,
  input  logic [dwc_pkg::COORD_W-1:0]     y,
  input  logic [dwc_pkg::PIX_W-1:0]       pix,
  input  logic [dwc_pkg::CAP_W-1:0]       cap,
  output dwc_pkg::res_list_t              list
);

  localparam int CW = dwc_pkg::COORD_W;
  localparam int PW = dwc_pkg::PITCH_W;
  localparam int BW = dwc_pkg::BASE_W;
  localparam int OW = dwc_pkg::OFFS_W;

  logic          open_r, open_nxt;
  logic [CW-1:0] left_r, left_nxt, top_r, top_nxt;
  logic [CW-1:0] full_r, full_nxt, cur_r, cur_nxt, bottom_r, bottom_nxt;
  // (bottom - top) * pitch, the offset of the last row
  logic [BW-1:0] base_r, base_nxt;

  logic [PW-1:0] pitch;
  logic [CW-1:0] dy;
  logic [BW-1:0] prod;
  logic [BW-1:0] grow_need;
  logic          y_next_row, must_close, kept, closing, two_draws;
  logic [1:0]    n_draw, n_all;
  dwc_pkg::result_t draw1, draw2, store;

  always_comb begin
    pitch      = PW'({1'b0, full_r} - {1'b0, left_r} + PW'(1));
    dy         = y - top_r;
    prod       = BW'(dy) * BW'(pitch);
    grow_need  = base_r + BW'({pitch, 1'b0});
    y_next_row = {1'b0, y} == ({1'b0, bottom_r} + PW'(1));

    must_close = open_r && (
      (x < left_r) ||
      ({1'b0, x} > ({1'b0, cur_r} + PW'(1))) ||
      ((y > bottom_r) && (cur_r < full_r)) ||
      ((top_r < bottom_r) && (x > full_r)) ||
      (y < top_r) ||
      ({1'b0, y} > ({1'b0, bottom_r} + PW'(1))) ||
      ((y > bottom_r) && (grow_need > BW'(cap))));

    kept      = open_r && !must_close;
    closing   = open_r && ((cmd == dwc_pkg::CMD_FLUSH) || must_close);
    two_draws = (cur_r != full_r) && (bottom_r != top_r);

    draw1        = '0;
    draw1.kind   = dwc_pkg::KIND_DRAW;
    draw1.left   = left_r;
    draw1.top    = top_r;
    draw1.right  = full_r;
    draw1.bottom = two_draws ? bottom_r - CW'(1) : bottom_r;

    draw2        = '0;
    draw2.kind   = dwc_pkg::KIND_DRAW;
    draw2.offset = base_r[OW-1:0];
    draw2.left   = left_r;
    draw2.top    = bottom_r;
    draw2.right  = cur_r;
    draw2.bottom = bottom_r;

    store        = '0;
    store.kind   = dwc_pkg::KIND_STORE;
    store.pixel  = pix & dwc_pkg::PIX_MASK;
    store.offset = kept ? OW'(x - left_r) + prod[OW-1:0] : '0;

    n_draw = closing ? (two_draws ? 2'd2 : 2'd1) : 2'd0;
    n_all  = n_draw + ((cmd == dwc_pkg::CMD_WRITE) ? 2'd1 : 2'd0);

    list.n       = n_all;
    list.item[0] = closing ? draw1 : store;
    list.item[1] = (closing && two_draws) ? draw2 : store;
    list.item[2] = store;
    for (int i = 0; i < 3; i++) begin
      list.item[i].last = (n_all == 2'(i + 1));
    end
  end

  always_comb begin
    open_nxt   = open_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    full_nxt   = full_r;
    cur_nxt    = cur_r;
    bottom_nxt = bottom_r;
    base_nxt   = base_r;
    if (accept) begin
      if (cmd == dwc_pkg::CMD_FLUSH) begin
        open_nxt = 1'b0;
      end else if (!kept) begin
        // open a fresh window at this pixel
        open_nxt   = 1'b1;
        left_nxt   = x;
        full_nxt   = x;
        cur_nxt    = x;
        top_nxt    = y;
        bottom_nxt = y;
        base_nxt   = '0;
      end else if (y_next_row) begin
        bottom_nxt = y;
        cur_nxt    = x;
        base_nxt   = base_r + BW'(pitch);
      end else if (x > cur_r) begin
        cur_nxt = x;
        if (top_r == bottom_r) begin
          full_nxt = x;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      left_r   <= '0;
      top_r    <= '0;
      full_r   <= '0;
      cur_r    <= '0;
      bottom_r <= '0;
      base_r   <= '0;
    end else begin
      open_r   <= open_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      full_r   <= full_nxt;
      cur_r    <= cur_nxt;
      bottom_r <= bottom_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule

// ===== src/dwc_result_queue.sv =====
// ----------------------------------------------------------------------------
// dwc_result_queue
// three-slot result register, loaded with one list, drained one a cycle while res_ready
// ----------------------------------------------------------------------------
module dwc_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  dwc_pkg::res_list_t  list,
  output logic                load_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output dwc_pkg::result_t    res
);

  dwc_pkg::result_t [2:0] slot_r;
  logic [1:0]             cnt_r;
  logic                   pop;

  assign pop        = res_valid && res_ready;
  assign res_valid  = (cnt_r != 2'd0);
  assign res        = slot_r[0];
  // a new list may land when nothing waits or the last waiting result leaves this cycle
  assign load_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && res_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= list.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= list.item;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule

// ===== sim/display_write_coalescer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_write_coalescer_top_tb
// self-checking bench for the display write coalescer
// ----------------------------------------------------------------------------
// pixel writes and flushes go in through the input stream. a model of the
// dirty window inside the bench works out every store and draw rectangle,
// and each result transfer is checked in order against it. register settings
// change between phases while the block is idle, and in all but two phases
// both streams idle in random bursts.
// ----------------------------------------------------------------------------
module display_write_coalescer_top_tb;

  // index with no register behind it; writes there must change nothing
  localparam logic [dwc_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic                        cmd;
    logic [dwc_pkg::COORD_W-1:0] x;
    logic [dwc_pkg::COORD_W-1:0] y;
    logic [dwc_pkg::PIX_W-1:0]   pix;
  } pixel_cmd_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // input stream
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata  = '0;                 // x, y, pixel_value, zero pad
  logic        in_tuser  = dwc_pkg::CMD_WRITE; // cmd

  // result stream
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;            // buffer_offset, store_pixel, left, top,
                                     // right, bottom
  logic        out_tuser;            // kind
  logic        out_tlast;            // last

  // configuration writes
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [dwc_pkg::IDX_W-1:0] cfg_index = dwc_pkg::REG_ROW_WIDTH;
  logic [dwc_pkg::CFG_W-1:0] cfg_data  = '0;

  display_write_coalescer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --------------------------------------------------------------------------
  // window model: own copy of the registers and the dirty window
  // --------------------------------------------------------------------------
  logic [dwc_pkg::RW_W-1:0]    row_width_r = dwc_pkg::ROW_WIDTH_RST;
  logic [dwc_pkg::BR_W-1:0]    buf_rows_r  = dwc_pkg::BUF_ROWS_RST;
  logic                        win_open    = 1'b0;
  logic [dwc_pkg::COORD_W-1:0] win_left    = '0;
  logic [dwc_pkg::COORD_W-1:0] win_top     = '0;
  logic [dwc_pkg::COORD_W-1:0] full_right  = '0;
  logic [dwc_pkg::COORD_W-1:0] cur_right   = '0;
  logic [dwc_pkg::COORD_W-1:0] win_bottom  = '0;

  dwc_pkg::result_t store_draw_q[$];  // stores and draws still to come out
  pixel_cmd_t       cmd_q[$];         // commands waiting for the input stream

  int err_count    = 0;
  int n_cmds       = 0;
  int n_results    = 0;
  int n_stores     = 0;
  int n_draws      = 0;
  int n_wrapped    = 0;
  int n_reg_writes = 0;
  int n_queued     = 0;
  int last_x       = 0;
  int last_y       = 0;

  // idle control, percent chance of starting a burst per free slot
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int in_gap       = 0;
  int out_gap      = 0;

  function automatic dwc_pkg::result_t make_result(
      input logic kind, input int offs,
      input logic [dwc_pkg::PIX_W-1:0] pix,
      input logic [dwc_pkg::COORD_W-1:0] l, t, r, b,
      input logic fin);
    dwc_pkg::result_t res;
    res.kind   = kind;
    res.offset = dwc_pkg::OFFS_W'(offs);
    res.pixel  = pix;
    res.left   = l;
    res.top    = t;
    res.right  = r;
    res.bottom = b;
    res.last   = fin;
    return res;
  endfunction

  // true when a write at (x, y) cannot join the open window
  function automatic bit breaks_window(input logic [dwc_pkg::COORD_W-1:0] x, y);
    int pitch_px;
    int capacity;
    pitch_px = int'(full_right) - int'(win_left) + 1;
    capacity = int'(row_width_r) * int'(buf_rows_r);
    if (!win_open) return 1'b0;
    if (x < win_left) return 1'b1;
    if (int'(x) > int'(cur_right) + 1) return 1'b1;
    if (y > win_bottom && cur_right < full_right) return 1'b1;
    if (win_top < win_bottom && x > full_right) return 1'b1;
    if (y < win_top) return 1'b1;
    if (int'(y) > int'(win_bottom) + 1) return 1'b1;
    if (y > win_bottom && pitch_px * (int'(y) - int'(win_top) + 1) > capacity)
      return 1'b1;
    return 1'b0;
  endfunction

  // close the window: one draw, or full rows then the odd last row
  task automatic emit_draws(input logic fin);
    int pitch_px;
    pitch_px = int'(full_right) - int'(win_left) + 1;
    if (win_open) begin
      if (cur_right == full_right || win_bottom == win_top) begin
        store_draw_q.push_back(make_result(dwc_pkg::KIND_DRAW, 0, '0, win_left,
                                           win_top, full_right, win_bottom, fin));
      end else begin
        store_draw_q.push_back(make_result(dwc_pkg::KIND_DRAW, 0, '0, win_left,
                                           win_top, full_right,
                                           win_bottom - 1'b1, 1'b0));
        store_draw_q.push_back(make_result(dwc_pkg::KIND_DRAW,
                                           (int'(win_bottom) - int'(win_top)) * pitch_px,
                                           '0, win_left, win_bottom, cur_right,
                                           win_bottom, fin));
      end
      win_open = 1'b0;
    end
  endtask

  task automatic coalesce_cmd(input logic cmd, input logic [dwc_pkg::COORD_W-1:0] x, y,
                              input logic [dwc_pkg::PIX_W-1:0] pix);
    int offs;
    if (cmd == dwc_pkg::CMD_FLUSH) begin
      emit_draws(1'b1);
    end else begin
      if (breaks_window(x, y)) emit_draws(1'b0);
      if (!win_open) begin
        win_open   = 1'b1;
        win_left   = x;
        full_right = x;
        cur_right  = x;
        win_top    = y;
        win_bottom = y;
      end
      // first write of the next row
      if (int'(y) == int'(win_bottom) + 1) begin
        win_bottom = y;
        cur_right  = x;
      end
      if (x > cur_right) begin
        if (win_top == win_bottom) full_right = x;
        cur_right = x;
      end
      offs = (int'(x) - int'(win_left)) +
             (int'(y) - int'(win_top)) * (int'(full_right) - int'(win_left) + 1);
      if (offs >= (1 << dwc_pkg::OFFS_W)) n_wrapped++;
      store_draw_q.push_back(make_result(dwc_pkg::KIND_STORE, offs,
                                         pix & dwc_pkg::PIX_MASK,
                                         '0, '0, '0, '0, 1'b1));
    end
  endtask

  // --------------------------------------------------------------------------
  // mismatch reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_count < 40)
      $display("mismatch at result %0d (t=%0t): %s", n_results, $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // input driver: one command per transfer, random idle bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    pixel_cmd_t c;
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0 && in_idle_pct > 0 &&
                   $urandom_range(0, 99) < in_idle_pct) begin
        // start an idle burst; in_gap counts the idle slots still to follow
        in_gap    <= $urandom_range(0, 13);
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0000, c.pix, c.y, c.x};
        in_tuser  <= c.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin : result_stall
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap    <= $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check result transfers first, then fold in register writes and
  // accepted commands, all on values sampled at the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    dwc_pkg::result_t got;
    dwc_pkg::result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind   = out_tuser;
        got.offset = out_tdata[15:0];
        got.pixel  = out_tdata[31:16];
        got.left   = out_tdata[41:32];
        got.top    = out_tdata[51:42];
        got.right  = out_tdata[61:52];
        got.bottom = out_tdata[71:62];
        got.last   = out_tlast;
        if (store_draw_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = store_draw_q.pop_front();
          check_field("kind",   got.kind,   want.kind);
          check_field("offset", got.offset, want.offset);
          check_field("pixel",  got.pixel,  want.pixel);
          check_field("left",   got.left,   want.left);
          check_field("top",    got.top,    want.top);
          check_field("right",  got.right,  want.right);
          check_field("bottom", got.bottom, want.bottom);
          check_field("last",   got.last,   want.last);
          if (want.kind == dwc_pkg::KIND_DRAW) n_draws++;
          else n_stores++;
        end
        n_results++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dwc_pkg::REG_ROW_WIDTH: row_width_r = cfg_data;
          dwc_pkg::REG_BUF_ROWS:  buf_rows_r  = cfg_data[dwc_pkg::BR_W-1:0];
          default: ;
        endcase
        n_reg_writes++;
      end
      if (in_tvalid && in_tready) begin
        coalesce_cmd(in_tuser, in_tdata[9:0], in_tdata[19:10], in_tdata[35:20]);
        n_cmds++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_write(input int x, input int y, input int pix);
    pixel_cmd_t c;
    c.cmd = dwc_pkg::CMD_WRITE;
    c.x   = dwc_pkg::COORD_W'(x);
    c.y   = dwc_pkg::COORD_W'(y);
    c.pix = dwc_pkg::PIX_W'(pix);
    cmd_q.push_back(c);
    last_x = x;
    last_y = y;
    n_queued++;
  endtask

  // x and y of a flush carry random junk
  task automatic push_flush();
    pixel_cmd_t c;
    c.cmd = dwc_pkg::CMD_FLUSH;
    c.x   = dwc_pkg::COORD_W'($urandom);
    c.y   = dwc_pkg::COORD_W'($urandom);
    c.pix = dwc_pkg::PIX_W'($urandom);
    cmd_q.push_back(c);
    n_queued++;
  endtask

  task automatic write_reg(input logic [dwc_pkg::IDX_W-1:0] idx,
                           input logic [dwc_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idle(input int in_pct, input int out_pct);
    in_idle_pct  <= in_pct;
    out_idle_pct <= out_pct;
  endtask

  // everything sent and checked, then a further wait for a flush that had no
  // window and so gives nothing to wait on
  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_tvalid || store_draw_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // let capacity follow a register write through the configuration register, then the capacity register
  task automatic settle_regs();
    repeat (3) @(posedge clk);
  endtask

  // row-by-row writes; later rows may start mid-row, the last may stop short
  task automatic raster(input int x0, input int y0, input int w, input int rows);
    int xs;
    int xe;
    for (int r = 0; r < rows; r++) begin
      xs = (r > 0 && $urandom_range(0, 3) == 0) ? $urandom_range(x0, x0 + w - 1) : x0;
      xe = (r == rows - 1 && $urandom_range(0, 1) == 0) ?
           $urandom_range(xs, x0 + w - 1) : x0 + w - 1;
      for (int c = xs; c <= xe; c++) push_write(c, y0 + r, $urandom);
      // rewrite a pixel already inside the window
      if ($urandom_range(0, 7) == 0) push_write(x0, y0, $urandom);
    end
  endtask

  task automatic random_traffic(input int count);
    int target;
    int pick;
    int w;
    int rows;
    int x0;
    int y0;
    int nx;
    int ny;
    target = n_queued + count;
    while (n_queued < target) begin
      pick = $urandom_range(0, 99);
      w    = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      rows = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) begin
        // hug the bottom right corner
        x0 = 1024 - w;
        y0 = 1024 - rows;
      end else begin
        x0 = $urandom_range(0, 1024 - w);
        y0 = $urandom_range(0, 1024 - rows);
      end
      if (pick < 60) begin
        raster(x0, y0, w, rows);
      end else if (pick < 68) begin
        // single row, then a new row one past its right edge
        raster(x0, y0, w, 1);
        if (x0 + w <= 1023 && y0 + 1 <= 1023) begin
          push_write(x0 + w, y0 + 1, $urandom);
          if ($urandom_range(0, 1) == 0) push_write(x0 + w, y0 + 1, $urandom);
        end
      end else if (pick < 80) begin
        push_write($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      end else if (pick < 90) begin
        // near the last write, often just off the window's edge
        nx = last_x + $urandom_range(0, 4) - 2;
        ny = last_y + $urandom_range(0, 2) - 1;
        nx = (nx < 0) ? 0 : (nx > 1023) ? 1023 : nx;
        ny = (ny < 0) ? 0 : (ny > 1023) ? 1023 : ny;
        push_write(nx, ny, $urandom);
      end else begin
        push_flush();
      end
    end
  endtask

  // tall window with a 256 pixel pitch so store offsets run past 16 bits
  task automatic wrap_sweep();
    for (int c = 0; c < 256; c++) push_write(700 + c, 0, $urandom);
    for (int r = 1; r < 257; r++) begin
      // starting the row at its right edge completes it in one write
      push_write(955, r, $urandom);
      if ($urandom_range(0, 31) == 0) push_write($urandom_range(700, 955), r, $urandom);
    end
    push_flush();
  endtask

  task automatic directed_cases();
    push_flush();                          // flush with no window open
    push_write(0, 0, 16'h0000);
    push_write(1, 0, 16'hFFFF);
    push_write(2, 0, 16'hA5A5);
    push_write(0, 1, 16'h5A5A);            // short second row
    push_flush();                          // full rows, then the partial row
    push_write(1023, 1023, 16'hFFFF);      // far corner
    push_write(1023, 1022, 16'h0001);      // above the window
    push_write(10, 5, $urandom);
    push_write(11, 5, $urandom);
    push_write(12, 5, $urandom);
    push_write(13, 6, $urandom);           // new row one past the right edge
    push_flush();                          // second draw wider than the first
    push_write(20, 8, $urandom);
    push_write(19, 8, $urandom);           // left of the window
    push_write(30, 9, $urandom);           // gap to the right on the next row
    push_write(30, 11, $urandom);          // skips a row
    push_write(50, 20, $urandom);
    push_write(51, 20, $urandom);
    push_write(50, 21, $urandom);
    push_write(50, 22, $urandom);          // row below a short row
    push_write(60, 30, $urandom);
    push_write(61, 30, $urandom);
    push_write(60, 31, $urandom);
    push_write(61, 31, $urandom);
    push_write(62, 31, $urandom);          // past the full rows' right edge
    push_flush();
  endtask

  // --------------------------------------------------------------------------
  // run sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // reset values of the registers
    set_idle(30, 30);
    directed_cases();
    wait_drained();

    // capacity of one pixel: a first row wider than capacity, then a new row
    write_reg(dwc_pkg::REG_ROW_WIDTH, dwc_pkg::CFG_W'(1));
    write_reg(dwc_pkg::REG_BUF_ROWS, dwc_pkg::CFG_W'(1));
    settle_regs();
    push_write(0, 0, $urandom);
    push_write(1, 0, $urandom);
    push_write(2, 0, $urandom);
    push_write(0, 1, $urandom);
    push_flush();
    random_traffic(10);
    wait_drained();

    // capacity zero: every new row closes the window
    write_reg(dwc_pkg::REG_ROW_WIDTH, dwc_pkg::CFG_W'(0));
    settle_regs();
    push_write(5, 5, $urandom);
    push_write(6, 5, $urandom);
    push_write(5, 6, $urandom);
    push_flush();
    random_traffic(10);
    wait_drained();

    // largest legal setting, no idling on either side
    write_reg(dwc_pkg::REG_ROW_WIDTH, dwc_pkg::CFG_W'(1024));
    write_reg(dwc_pkg::REG_BUF_ROWS, dwc_pkg::CFG_W'(64));
    settle_regs();
    set_idle(0, 0);
    random_traffic(20);
    wait_drained();

    // all register bits set, tall window for offset wrap
    write_reg(dwc_pkg::REG_ROW_WIDTH, dwc_pkg::CFG_W'(2047));
    write_reg(dwc_pkg::REG_BUF_ROWS, dwc_pkg::CFG_W'(127));
    settle_regs();
    set_idle(10, 10);
    wrap_sweep();
    wait_drained();

    // small buffer so capacity bites often, heavy idling
    write_reg(dwc_pkg::REG_ROW_WIDTH, dwc_pkg::CFG_W'($urandom_range(16, 40)));
    write_reg(dwc_pkg::REG_BUF_ROWS, dwc_pkg::CFG_W'($urandom_range(1, 4)));
    settle_regs();
    set_idle(40, 40);
    random_traffic(25);
    wait_drained();

    // random setting, junk above the row count bits, a write to no register
    write_reg(REG_UNUSED, dwc_pkg::CFG_W'($urandom));
    write_reg(dwc_pkg::REG_ROW_WIDTH, dwc_pkg::CFG_W'($urandom_range(1, 1024)));
    write_reg(dwc_pkg::REG_BUF_ROWS,
              dwc_pkg::CFG_W'(($urandom_range(0, 15) << dwc_pkg::BR_W) |
                              $urandom_range(1, 64)));
    settle_regs();
    set_idle(20, 50);
    random_traffic(20);
    wait_drained();

    // back to the reset values, full rate to the end
    write_reg(dwc_pkg::REG_ROW_WIDTH, dwc_pkg::CFG_W'(dwc_pkg::ROW_WIDTH_RST));
    write_reg(dwc_pkg::REG_BUF_ROWS, dwc_pkg::CFG_W'(dwc_pkg::BUF_ROWS_RST));
    settle_regs();
    set_idle(0, 0);
    random_traffic(25);
    wait_drained();
    repeat (16) @(posedge clk);

    $display("checked %0d commands giving %0d stores and %0d draw rectangles",
             n_cmds, n_stores, n_draws);
    $display("over %0d register writes; %0d store offsets wrapped past 16 bits",
             n_reg_writes, n_wrapped);
    if (err_count == 0) begin
      $display("PASS display_write_coalescer_top");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL display_write_coalescer_top");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("timeout with %0d results outstanding and %0d commands unsent",
             store_draw_q.size(), cmd_q.size());
    $display("FAIL display_write_coalescer_top");
    $finish;
  end

endmodule

// ===== files.f =====
src/dwc_pkg.sv
src/dwc_cfg_regs.sv
src/dwc_window.sv
src/dwc_result_queue.sv
src/display_write_coalescer_top.sv
sim/display_write_coalescer_top_tb.sv
